// ----- hw/rtl/window_cache_directory_lru_top_assert.svh -----
// ----------------------------------------------------------------------------
// Window cache directory assertion macros
// Shared concurrent assertion forms for the directory RTL.
// ----------------------------------------------------------------------------
`ifndef WINDOW_CACHE_DIRECTORY_LRU_TOP_ASSERT_SVH
`define WINDOW_CACHE_DIRECTORY_LRU_TOP_ASSERT_SVH

// implication checked on every edge outside reset
`define WCD_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define WCD_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- hw/rtl/wcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Window cache directory package
// Commands, status codes, register indexes and shared command/status types.
// ----------------------------------------------------------------------------
`default_nettype none
package wcd_pkg;
   localparam int unsigned MaxSize = 4096;
   localparam int unsigned MaxNpw  = 1024;

   typedef enum logic [1:0] {
      CMD_READ = 2'd0, CMD_WRITE = 2'd1, CMD_FILL = 2'd2, CMD_INVAL = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_HIT = 3'd0, ST_MISS = 3'd1, ST_WRITTEN = 3'd2, ST_DONE = 3'd3,
      ST_REFUSED = 3'd4
   } status_type;

   localparam logic [2:0] REG_START = 3'd0;
   localparam logic [2:0] REG_SIZE  = 3'd1;
   localparam logic [2:0] REG_NPW   = 3'd2;
   localparam logic [2:0] REG_WAYS  = 3'd3;
   localparam logic [2:0] REG_INIT  = 3'd4;

   typedef struct packed {
      logic load;     // capture request, compute position
      logic search;   // way search, choose victim
      logic div_init; // start division of fill length
      logic div_step; // divider step, two quotient bits
      logic commit;   // update state, form result
   } cmd_ctl_type;

   typedef struct packed {
      logic div_done;
   } dp_stat_type;
endpackage
`default_nettype wire

// ----- hw/rtl/wcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Window cache directory controller
// Sequences load, search, division and commit for one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module wcd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      res_load,
   input  wire logic                 res_free,
   output wcd_pkg::cmd_ctl_type      ctl,
   input  wire wcd_pkg::dp_stat_type stat
);
   import wcd_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_SRCH = 5'b00010, S_DIV = 5'b00100, S_DIVR = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      res_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            ctl.search   = 1'b1;
            ctl.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            ctl.div_step = 1'b1;
            if (stat.div_done) state_in = S_DIVR;
         end
         S_DIVR: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (res_free) begin
               ctl.commit = 1'b1;
               res_load   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   `include "window_cache_directory_lru_top_assert.svh"
   `WCD_ASSERT_NEXT(a_load_search, clock, reset, ctl.load, state_ff == S_SRCH, "no search")
   `WCD_ASSERT_IMPL(a_commit_free, clock, reset, ctl.commit, res_free, "commit blocked")
   `WCD_ASSERT_IMPL(a_stall_busy, clock, reset, state_ff != S_IDLE, req_stall, "accept busy")
endmodule
`default_nettype wire

// ----- hw/rtl/wcd_datapath.sv -----
// ----------------------------------------------------------------------------
// Window cache directory datapath
// Configuration, way table, LRU choice, serial divider and result forming.
// ----------------------------------------------------------------------------
`default_nettype none
module wcd_datapath #(
   parameter int unsigned NWAYS = 4,
   parameter int unsigned MIN_ENTRIES_PER_WAY = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   input  wire logic [2:0]           csr_index,
   input  wire logic [31:0]          csr_data,
   input  wire logic [1:0]           req_cmd,
   input  wire logic [23:0]          req_entry_index,
   input  wire logic                 req_has_data,
   input  wire logic [22:0]          req_fill_bytes,
   input  wire logic                 req_set_count,
   input  wire logic [23:0]          req_new_count,
   input  wire wcd_pkg::cmd_ctl_type ctl,
   output wcd_pkg::dp_stat_type      stat,
   output logic [2:0]                r_status,
   output logic [1:0]                r_way,
   output logic [21:0]               r_offset,
   output logic [31:0]               r_soff,
   output logic [22:0]               r_req,
   output logic [10:0]               r_loaded,
   output logic [24:0]               r_count
);
   import wcd_pkg::*;

   localparam int WB = (NWAYS > 1) ? $clog2(NWAYS) : 1;
   localparam int CB = $clog2(NWAYS + 1);
   localparam logic [31:0] IntMax = 32'h7FFF_FFFF;

   logic [31:0] start_ff;
   logic [12:0] size_ff;
   logic [10:0] npw_ff;
   logic [2:0]  ways_ff;
   logic [31:0] win_start_ff [NWAYS];
   logic [22:0] win_len_ff   [NWAYS];
   logic [31:0] last_use_ff  [NWAYS];
   logic [31:0] timer_ff;
   logic [CB-1:0] in_use_ff;
   logic [24:0] count_ff;
   logic        pend_ff;
   logic [WB-1:0] pend_way_ff;
   logic [31:0] pend_start_ff;

   logic [1:0]  cmd_ff;
   logic [23:0] ei_ff, newc_ff;
   logic        hd_ff, setc_ff;
   logic [22:0] fill_ff;
   logic [31:0] pos_ff;
   logic        hit_ff;
   logic [WB-1:0] hway_ff, vway_ff;
   logic        vevict_ff;
   logic [22:0] len_ff;
   logic [4:0]  dcnt_ff;
   logic [22:0] wsize_ff;

   logic [12:0] esize;
   logic [10:0] enpw;
   logic [CB-1:0] eways;
   always_comb begin
      esize = (size_ff == 13'd0) ? 13'd1 : (size_ff > 13'(MaxSize)) ? 13'(MaxSize) : size_ff;
      enpw  = (npw_ff < 11'(MIN_ENTRIES_PER_WAY)) ? 11'(MIN_ENTRIES_PER_WAY) : npw_ff;
      if (enpw > 11'(MaxNpw)) enpw = 11'(MaxNpw);
      if (ways_ff == 3'd0) eways = CB'(1);
      else if (32'(ways_ff) > NWAYS) eways = CB'(NWAYS);
      else eways = CB'(ways_ff);
   end

   // search
   logic          hit_c;
   logic [WB-1:0] hway_c, vway_c;
   logic          vfound, vevict_c;
   logic [31:0]   oldest;
   logic [CB-1:0] lim;
   always_comb begin
      hit_c = 1'b0; hway_c = '0; vway_c = '0; vfound = 1'b0; oldest = IntMax;
      vevict_c = 1'b0;
      lim = (in_use_ff < eways) ? in_use_ff : eways;
      for (int w = NWAYS - 1; w >= 0; w--) begin
         if (CB'(w) < in_use_ff && win_len_ff[w] != '0 && pos_ff >= win_start_ff[w] &&
             {1'b0, pos_ff} < {1'b0, win_start_ff[w]} + 33'(win_len_ff[w])) begin
            hit_c = 1'b1; hway_c = WB'(w);
         end
      end
      for (int w = NWAYS - 1; w >= 0; w--)
         if (CB'(w) < lim && win_len_ff[w] == '0) begin vfound = 1'b1; vway_c = WB'(w); end
      if (!vfound && in_use_ff < eways) begin
         vfound = 1'b1; vway_c = WB'(in_use_ff);
      end
      if (!vfound) begin
         vevict_c = 1'b1;
         for (int w = 0; w < NWAYS; w++)
            if (CB'(w) < eways && last_use_ff[w] < oldest) begin
               oldest = last_use_ff[w]; vway_c = WB'(w);
            end
      end
   end

   assign stat.div_done = (dcnt_ff == 5'd0);

   logic [24:0] wr_count;
   assign wr_count = ({1'b0, ei_ff} >= count_ff) ? 25'(ei_ff) + 25'd1 : count_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_cmd; ei_ff <= req_entry_index; hd_ff <= req_has_data;
         fill_ff <= req_fill_bytes; setc_ff <= req_set_count; newc_ff <= req_new_count;
         pos_ff <= start_ff + ({8'd0, req_entry_index} * {19'd0, esize});
         wsize_ff <= {12'd0, enpw} * {10'd0, esize};
      end
      if (ctl.search) begin
         hit_ff <= hit_c; hway_ff <= hway_c; vway_ff <= vway_c; vevict_ff <= vevict_c;
         len_ff <= (fill_ff > wsize_ff) ? wsize_ff : fill_ff;
      end
      // pace the controller over the divider steps
      if (ctl.div_init) begin
         dcnt_ff <= 5'd11;
      end else if (ctl.div_step && dcnt_ff != 5'd0) begin
         dcnt_ff <= dcnt_ff - 5'd1;
      end
   end

   // restoring divide of the fill length by the entry size, two bits a cycle
   logic [22:0] dq_ff, dr_ff;
   logic [4:0]  dk_ff;
   logic [23:0] dt1, dt2;
   logic [22:0] dr1, dq1;
   always_comb begin
      dt1 = {dr_ff, dq_ff[22]} - 24'(esize);
      dr1 = dt1[23] ? {dr_ff[21:0], dq_ff[22]} : dt1[22:0];
      dq1 = {dq_ff[21:0], ~dt1[23]};
      dt2 = {dr1, dq1[22]} - 24'(esize);
   end
   always_ff @(posedge clock) begin
      if (ctl.div_init) begin
         dq_ff <= (fill_ff > wsize_ff) ? wsize_ff : fill_ff; dr_ff <= '0; dk_ff <= 5'd0;
      end else if (ctl.div_step || dk_ff < 5'd23) begin
         if (dk_ff < 5'd23) begin
            if (dk_ff == 5'd22) begin
               dr_ff <= dr1; dq_ff <= dq1; dk_ff <= 5'd23;
            end else begin
               dr_ff <= dt2[23] ? {dr1[21:0], dq1[22]} : dt2[22:0];
               dq_ff <= {dq1[21:0], ~dt2[23]};
               dk_ff <= dk_ff + 5'd2;
            end
         end
      end
   end

   // result and state update
   logic [31:0] hstart;
   logic [22:0] flen;
   logic [10:0] nent;
   assign hstart = win_start_ff[hway_ff];
   assign nent = dq_ff[10:0];
   assign flen = {12'd0, nent} * {10'd0, esize};

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         r_status <= ST_REFUSED; r_way <= '0; r_offset <= '0; r_soff <= '0;
         r_req <= '0; r_loaded <= '0;
         r_count <= count_ff;
         unique case (cmd_type'(cmd_ff))
            CMD_READ: if (!pend_ff) begin
               r_soff <= pos_ff;
               if (hit_ff) begin
                  r_status <= ST_HIT; r_way <= 2'(hway_ff);
                  r_offset <= 22'(pos_ff - hstart); r_loaded <= 11'd1;
               end else begin
                  r_status <= ST_MISS; r_way <= 2'(vway_ff); r_req <= wsize_ff;
               end
            end
            CMD_WRITE: if (!pend_ff) begin
               if (hit_ff || hd_ff) begin
                  r_status <= ST_WRITTEN; r_soff <= pos_ff; r_req <= 23'(esize);
                  r_count <= wr_count;
                  if (hit_ff) begin
                     r_way <= 2'(hway_ff); r_offset <= 22'(pos_ff - hstart);
                  end
               end else r_status <= ST_DONE;
            end
            CMD_FILL: if (pend_ff) begin
               r_status <= ST_DONE; r_way <= 2'(pend_way_ff); r_soff <= pend_start_ff;
               r_req <= len_ff;
               if (len_ff != '0) r_loaded <= nent;
            end
            CMD_INVAL: begin
               r_status <= ST_DONE;
               if (setc_ff) r_count <= 25'(newc_ff);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0; size_ff <= 13'd64; npw_ff <= 11'd16; ways_ff <= 3'd4;
         count_ff <= '0; timer_ff <= '0; in_use_ff <= '0; pend_ff <= 1'b0;
         pend_way_ff <= '0; pend_start_ff <= '0;
         for (int w = 0; w < NWAYS; w++) begin
            win_start_ff[w] <= '0; win_len_ff[w] <= '0; last_use_ff[w] <= '0;
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_START: start_ff <= csr_data;
               REG_SIZE:  size_ff  <= csr_data[12:0];
               REG_NPW:   npw_ff   <= csr_data[10:0];
               REG_WAYS:  ways_ff  <= csr_data[2:0];
               REG_INIT:  count_ff <= {1'b0, csr_data[23:0]};
               default: ;
            endcase
         end
         if (ctl.commit) begin
            unique case (cmd_type'(cmd_ff))
               CMD_READ: if (!pend_ff) begin
                  if (hit_ff) begin
                     timer_ff <= timer_ff + 32'd1;
                     last_use_ff[hway_ff] <= timer_ff + 32'd1;
                  end else begin
                     if (vevict_ff) begin
                        win_start_ff[vway_ff] <= '0; win_len_ff[vway_ff] <= '0;
                        last_use_ff[vway_ff] <= '0;
                     end
                     pend_ff <= 1'b1; pend_way_ff <= vway_ff; pend_start_ff <= pos_ff;
                  end
               end
               CMD_WRITE: if (!pend_ff) begin
                  if (hit_ff) begin
                     timer_ff <= timer_ff + 32'd1;
                     last_use_ff[hway_ff] <= timer_ff + 32'd1;
                  end
                  if (hit_ff || hd_ff) count_ff <= wr_count;
               end
               CMD_FILL: if (pend_ff) begin
                  pend_ff <= 1'b0;
                  if (len_ff != '0) begin
                     win_start_ff[pend_way_ff] <= pend_start_ff;
                     win_len_ff[pend_way_ff] <= flen;
                     timer_ff <= timer_ff + 32'd1;
                     last_use_ff[pend_way_ff] <= timer_ff + 32'd1;
                     if (in_use_ff < eways) in_use_ff <= in_use_ff + CB'(1);
                  end
               end
               CMD_INVAL: begin
                  for (int w = 0; w < NWAYS; w++) begin
                     win_start_ff[w] <= '0; win_len_ff[w] <= '0; last_use_ff[w] <= '0;
                  end
                  pend_ff <= 1'b0;
                  if (setc_ff) count_ff <= 25'(newc_ff);
               end
               default: ;
            endcase
         end
      end
   end

   `include "window_cache_directory_lru_top_assert.svh"
   `WCD_ASSERT_IMPL(a_use_bound, clock, reset, 1'b1, in_use_ff <= CB'(NWAYS), "ways overrun")
   `WCD_ASSERT_NEXT(a_div_done, clock, reset, ctl.div_init, dk_ff == 5'd0, "divider start")
   `WCD_ASSERT_IMPL(a_commit_div, clock, reset, ctl.commit, dk_ff == 5'd23, "divider busy")
endmodule
`default_nettype wire

// ----- hw/rtl/window_cache_directory_lru_top.sv -----
// ----------------------------------------------------------------------------
// Window cache directory with LRU replacement
// Fully associative directory of windows over a backing store.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command (read, write, fill completion, invalidate);
//   a transfer takes place when req_valid is high and req_stall low.
//   rsp_* returns exactly one result per command; the receiver holds
//   rsp_stall high to hold it, the payload then stays unchanged.
//   csr_* writes a register by index; the user must write only while the
//   block is idle, as the block itself does not enforce it. One command
//   at a time: load, search, a two-bit-per-cycle divider over the fill
//   length, one settle state and commit. Every command passes the
//   divider; a new transfer is taken only after the last result commits.
//   A finished result waits in the controller while the output register
//   still holds an earlier result under rsp_stall; req_stall stays high.
//   Synchronous reset empties every window, restores register defaults
//   and drops any pending fill; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module window_cache_directory_lru_top #(
   parameter int unsigned NWAYS = 4,
   parameter int unsigned MIN_ENTRIES_PER_WAY = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [23:0] req_entry_index,
   input  wire logic        req_has_data,
   input  wire logic [22:0] req_fill_bytes,
   input  wire logic        req_set_count,
   input  wire logic [23:0] req_new_count,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [1:0]       rsp_way,
   output logic [21:0]      rsp_offset_in_way,
   output logic [31:0]      rsp_store_offset,
   output logic [22:0]      rsp_request_bytes,
   output logic [10:0]      rsp_entries_loaded,
   output logic [24:0]      rsp_entry_count
);
   import wcd_pkg::*;

   cmd_ctl_type ctl;
   dp_stat_type stat;
   logic        res_load, res_free, rsp_valid_ff;

   assign csr_ready = 1'b1;
   assign res_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (res_load) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   wcd_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .res_load, .res_free, .ctl, .stat
   );

   wcd_datapath #(.NWAYS(NWAYS), .MIN_ENTRIES_PER_WAY(MIN_ENTRIES_PER_WAY)) u_dp (
      .clock, .reset, .csr_valid, .csr_index, .csr_data,
      .req_cmd, .req_entry_index, .req_has_data, .req_fill_bytes,
      .req_set_count, .req_new_count, .ctl, .stat,
      .r_status(rsp_status), .r_way(rsp_way), .r_offset(rsp_offset_in_way),
      .r_soff(rsp_store_offset), .r_req(rsp_request_bytes),
      .r_loaded(rsp_entries_loaded), .r_count(rsp_entry_count)
   );
endmodule
`default_nettype wire

// ----- sim/tb_window_cache_directory_lru_top.sv -----
// ----------------------------------------------------------------------------
// Window cache directory testbench
// Drives reads, writes, fill completions and invalidates under random idling
// and several register settings; a scoreboard predicts each result and
// compares it field by field with the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_window_cache_directory_lru_top;
   import wcd_pkg::*;

   localparam int NW = 4;
   localparam int MINE = 4;
   localparam int LIMIT = 1000000;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  way;
      logic [21:0] off;
      logic [31:0] soff;
      logic [22:0] req;
      logic [10:0] loaded;
      logic [24:0] count;
   } dir_result_type;

   class dir_scoreboard;
      logic [31:0] r_start;
      logic [12:0] r_size;
      logic [10:0] r_npw;
      logic [2:0]  r_ways;
      logic [31:0] win_start [NW];
      logic [22:0] win_len [NW];
      logic [31:0] stamp [NW];
      logic [31:0] timer;
      int unsigned used;
      logic [24:0] count;
      bit          pend;
      int unsigned pend_way;
      logic [31:0] pend_start;
      dir_result_type pending_q[$];
      int          errors;

      function void clear();
         r_start = 0; r_size = 64; r_npw = 16; r_ways = 4;
         for (int w = 0; w < NW; w++) begin
            win_start[w] = 0; win_len[w] = 0; stamp[w] = 0;
         end
         timer = 0; used = 0; count = 0; pend = 0; pend_way = 0; pend_start = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] d);
         case (idx)
            REG_START: r_start = d;
            REG_SIZE:  r_size = d[12:0];
            REG_NPW:   r_npw = d[10:0];
            REG_WAYS:  r_ways = d[2:0];
            REG_INIT:  count = {1'b0, d[23:0]};
            default: ;
         endcase
      endfunction

      function int unsigned esize();
         if (r_size == 0) return 1;
         if (r_size > 4096) return 4096;
         return r_size;
      endfunction

      function int unsigned enpw();
         if (r_npw < MINE) return MINE;
         if (r_npw > 1024) return 1024;
         return r_npw;
      endfunction

      function int unsigned eways();
         if (r_ways == 0) return 1;
         if (r_ways > NW) return NW;
         return r_ways;
      endfunction

      function int lookup(logic [31:0] pos);
         for (int w = 0; w < NW && w < used; w++) begin
            if (win_len[w] > 0 && pos >= win_start[w] &&
                {1'b0, pos} < {1'b0, win_start[w]} + win_len[w]) begin
               timer++;
               stamp[w] = timer;
               return w;
            end
         end
         return -1;
      endfunction

      function int unsigned victim();
         int unsigned act, lim, best;
         logic [31:0] oldest;
         act = eways();
         lim = used < act ? used : act;
         for (int unsigned w = 0; w < lim; w++)
            if (win_len[w] == 0) return w;
         if (used < act) return used;
         best = 0; oldest = 32'h7fffffff;
         for (int unsigned w = 0; w < act; w++)
            if (stamp[w] < oldest) begin
               best = w; oldest = stamp[w];
            end
         win_start[best] = 0; win_len[best] = 0; stamp[best] = 0;
         return best;
      endfunction

      function void note_request(cmd_type cmd, logic [23:0] idx, logic hd,
                                 logic [22:0] fb, logic sc, logic [23:0] nc);
         dir_result_type r;
         logic [31:0] pos;
         int h;
         int unsigned w, sz, len, n;
         r = '0;
         r.status = ST_REFUSED;
         pos = r_start + 32'(idx * esize());
         if (cmd == CMD_READ && !pend) begin
            h = lookup(pos);
            r.soff = pos;
            if (h >= 0) begin
               r.status = ST_HIT; r.way = 2'(h); r.off = 22'(pos - win_start[h]);
               r.loaded = 11'd1;
            end else begin
               w = victim();
               r.status = ST_MISS; r.way = 2'(w); r.req = 23'(enpw() * esize());
               pend = 1; pend_way = w; pend_start = pos;
            end
         end else if (cmd == CMD_WRITE && !pend) begin
            h = lookup(pos);
            if (h >= 0 || hd) begin
               r.status = ST_WRITTEN; r.soff = pos; r.req = 23'(esize());
               if (h >= 0) begin
                  r.way = 2'(h); r.off = 22'(pos - win_start[h]);
               end
               if ({1'b0, idx} >= count) count = {1'b0, idx} + 25'd1;
            end else r.status = ST_DONE;
         end else if (cmd == CMD_FILL && pend) begin
            sz = esize();
            len = fb > enpw() * sz ? enpw() * sz : 32'(fb);
            r.status = ST_DONE; r.way = 2'(pend_way); r.soff = pend_start;
            r.req = 23'(len);
            if (len > 0) begin
               n = len / sz;
               win_start[pend_way] = pend_start;
               win_len[pend_way] = 23'(n * sz);
               timer++;
               stamp[pend_way] = timer;
               if (used < eways()) used++;
               r.loaded = 11'(n);
            end
            pend = 0;
         end else if (cmd == CMD_INVAL) begin
            for (int i = 0; i < NW; i++) begin
               win_start[i] = 0; win_len[i] = 0; stamp[i] = 0;
            end
            pend = 0;
            if (sc) count = {1'b0, nc};
            r.status = ST_DONE;
         end
         r.count = count;
         pending_q.push_back(r);
      endfunction

      function void check_result(dir_result_type got);
         dir_result_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (got.status !== e.status) mismatch("status", e.status, got.status);
         if (got.way !== e.way) mismatch("way", e.way, got.way);
         if (got.off !== e.off) mismatch("offset_in_way", e.off, got.off);
         if (got.soff !== e.soff) mismatch("store_offset", e.soff, got.soff);
         if (got.req !== e.req) mismatch("request_bytes", e.req, got.req);
         if (got.loaded !== e.loaded) mismatch("entries_loaded", e.loaded, got.loaded);
         if (got.count !== e.count) mismatch("entry_count", e.count, got.count);
      endfunction

      function void mismatch(string f, logic [31:0] e, logic [31:0] a);
         $display("%0t: %s expected %h actual %h", $time, f, e, a);
         errors++;
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = 0;
   logic [31:0] csr_data = 0;
   logic req_valid = 0, req_stall;
   logic [1:0] req_cmd = 0;
   logic [23:0] req_entry_index = 0;
   logic req_has_data = 0;
   logic [22:0] req_fill_bytes = 0;
   logic req_set_count = 0;
   logic [23:0] req_new_count = 0;
   logic rsp_valid, rsp_stall = 0;
   logic [2:0] rsp_status;
   logic [1:0] rsp_way;
   logic [21:0] rsp_offset_in_way;
   logic [31:0] rsp_store_offset;
   logic [22:0] rsp_request_bytes;
   logic [10:0] rsp_entries_loaded;
   logic [24:0] rsp_entry_count;

   dir_scoreboard sb;
   bit quiet = 0;
   bit hold_rsp = 0;
   int cycles = 0;

   window_cache_directory_lru_top u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_window_cache_directory_lru_top failed");
         $finish;
      end
   end

   // receiver: random stall bursts, or a long hold when asked
   initial begin : rsp_side
      int n;
      forever begin
         @(posedge clock);
         if (hold_rsp) rsp_stall <= 1;
         else if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 16);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end else rsp_stall <= 0;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_status, rsp_way, rsp_offset_in_way, rsp_store_offset,
                          rsp_request_bytes, rsp_entries_loaded, rsp_entry_count});

   // valid stays high after a transfer until the next idle burst or drain
   task automatic send(cmd_type c, logic [23:0] idx, logic hd, logic [22:0] fb,
                       logic sc, logic [23:0] nc);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1; req_cmd <= c; req_entry_index <= idx; req_has_data <= hd;
      req_fill_bytes <= fb; req_set_count <= sc; req_new_count <= nc;
      do @(posedge clock); while (req_stall);
      sb.note_request(c, idx, hd, fb, sc, nc);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_reg(logic [2:0] idx, logic [31:0] d);
      csr_valid <= 1; csr_index <= idx; csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, d);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic rand_item(int unsigned span);
      int unsigned k;
      logic [23:0] idx;
      k = $urandom_range(0, 19);
      idx = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, span));
      if (sb.pend && k < 16)
         send(CMD_FILL, 24'($urandom), 1'($urandom), ($urandom_range(0, 7) == 0) ?
              23'($urandom) : 23'($urandom_range(0, 2 * sb.enpw() * sb.esize())),
              1'($urandom), 24'($urandom));
      else if (k < 10)
         send(CMD_READ, idx, 1'($urandom), 23'($urandom), 1'($urandom), 24'($urandom));
      else if (k < 17)
         send(CMD_WRITE, idx, 1'($urandom), 23'($urandom), 1'($urandom), 24'($urandom));
      else if (k < 19)
         send(CMD_FILL, idx, 1'($urandom), 23'($urandom), 1'($urandom), 24'($urandom));
      else send(CMD_INVAL, idx, 1'($urandom), 23'($urandom), 1'($urandom),
                24'($urandom_range(0, 200)));
   endtask

   initial begin : main
      sb = new();
      sb.clear();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send(CMD_FILL, 0, 0, 100, 0, 0);
      send(CMD_READ, 0, 0, 0, 0, 0);
      send(CMD_READ, 3, 0, 0, 0, 0);
      send(CMD_FILL, 0, 0, 23'h7fffff, 0, 0);
      send(CMD_READ, 5, 0, 0, 0, 0);
      send(CMD_READ, 24'hffffff, 0, 0, 0, 0);
      send(CMD_WRITE, 1, 1, 0, 0, 0);
      send(CMD_FILL, 0, 0, 0, 0, 0);
      send(CMD_READ, 24'hffffff, 0, 0, 0, 0);
      send(CMD_FILL, 0, 0, 100, 0, 0);
      send(CMD_READ, 24'hffffff, 0, 0, 0, 0);
      send(CMD_WRITE, 24'hffffff, 0, 0, 0, 0);
      send(CMD_WRITE, 24'h800000, 0, 0, 0, 0);
      send(CMD_WRITE, 24'h800000, 1, 0, 0, 0);
      send(CMD_INVAL, 0, 0, 0, 1, 24'hffffff);
      send(CMD_INVAL, 0, 0, 0, 0, 0);
      send(CMD_READ, 0, 0, 0, 0, 0);
      send(CMD_INVAL, 0, 0, 0, 1, 0);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               set_reg(REG_START, 0); set_reg(REG_SIZE, 64); set_reg(REG_NPW, 16);
               set_reg(REG_WAYS, 4); set_reg(REG_INIT, 0);
            end
            1: begin
               set_reg(REG_START, 32'hffffffc0); set_reg(REG_SIZE, 0);
               set_reg(REG_NPW, 0); set_reg(REG_WAYS, 0); set_reg(REG_INIT, 24'hffffff);
            end
            2: begin
               set_reg(REG_START, $urandom); set_reg(REG_SIZE, 13'h1fff);
               set_reg(REG_NPW, 11'h7ff); set_reg(REG_WAYS, 7); set_reg(REG_INIT, 5);
            end
            3: begin
               set_reg(REG_START, 32'hfffff000); set_reg(REG_SIZE, 4096);
               set_reg(REG_NPW, 1024); set_reg(REG_WAYS, 2);
               set_reg(REG_INIT, $urandom_range(0, 50));
            end
            4: begin
               set_reg(REG_START, $urandom_range(0, 1000)); set_reg(REG_SIZE, 1);
               set_reg(REG_NPW, 3); set_reg(REG_WAYS, 3); set_reg(REG_INIT, 0);
            end
            default: begin
               set_reg(REG_START, $urandom); set_reg(REG_SIZE, $urandom_range(1, 100));
               set_reg(REG_NPW, $urandom_range(1, 40)); set_reg(REG_WAYS, 4);
               set_reg(REG_INIT, $urandom);
            end
         endcase
         if (ph == 5) quiet = 1;
         for (int i = 0; i < 100; i++) begin
            if (ph == 2 && i == 40) begin
               fork
                  begin
                     hold_rsp = 1;
                     repeat (300) @(posedge clock);
                     hold_rsp = 0;
                  end
                  for (int j = 0; j < 10; j++) rand_item(100);
               join
            end
            if (ph == 3 && i == 50) drain();
            rand_item(ph == 1 ? 24'hffffff : 200);
         end
         drain();
      end
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("tb_window_cache_directory_lru_top passed");
      else
         $display("tb_window_cache_directory_lru_top failed");
      $finish;
   end
endmodule
`default_nettype wire
